FILE: src/offt_pkg.sv
`timescale 1ns / 1ps
// offt_pkg: shared widths, character codes, corner and triangle types
// for the face fan triangulator; no dependencies
package offt_pkg;

	localparam int INDEX_WIDTH = 24;
	localparam int IDX_W = 24;
	localparam int RANGE_W = (INDEX_WIDTH < IDX_W) ? INDEX_WIDTH : IDX_W;
	localparam int CHAR_W = 8;
	localparam int ACC_W = 25;
	localparam int NUM_FIELDS = 3;
	localparam int FIFO_DEPTH = 2;

	localparam logic [ACC_W-1:0] ACC_CAP = {ACC_W{1'b1}};
	localparam logic [ACC_W-1:0] ACC_SAT_LIM = ACC_W'((ACC_CAP - 9) / 10);

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	localparam logic [1:0] FIELD_POS = 2'd0;
	localparam logic [1:0] FIELD_TEX = 2'd1;
	localparam logic [1:0] FIELD_NRM = 2'd2;
	localparam logic [1:0] FAN_FULL  = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] tex;
		logic             tp;
		logic [IDX_W-1:0] nrm;
		logic             np;
		logic             err;
	} corner_t;

	typedef struct packed {
		corner_t c0;
		corner_t c1;
		corner_t c2;
		logic    last;
	} tri_t;

	typedef struct packed {
		logic push;
	} q_ctl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FIRST,
		BK_PREV,
		BK_CUR
	} back_state_t;

endpackage

FILE: src/offt_char_if.sv
`timescale 1ns / 1ps
// offt_char_if: character channel with counts, valid/ready handshake
// depends on offt_pkg
interface offt_char_if import offt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_line;
	logic [IDX_W-1:0]  position_count;
	logic [IDX_W-1:0]  texcoord_count;
	logic [IDX_W-1:0]  normal_count;

	modport source (output valid, char_code, end_of_line, position_count, texcoord_count,
		normal_count, input ready);
	modport sink (input valid, char_code, end_of_line, position_count, texcoord_count,
		normal_count, output ready);
endinterface

FILE: src/offt_corner_if.sv
`timescale 1ns / 1ps
// offt_corner_if: triangle corner channel, valid/ready handshake
// depends on offt_pkg
interface offt_corner_if import offt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] position_index;
	logic [IDX_W-1:0] texcoord_index;
	logic             texcoord_present;
	logic [IDX_W-1:0] normal_index;
	logic             normal_present;
	logic             index_error;
	logic             last_corner;

	modport source (output valid, position_index, texcoord_index, texcoord_present,
		normal_index, normal_present, index_error, last_corner, input ready);
	modport sink (input valid, position_index, texcoord_index, texcoord_present,
		normal_index, normal_present, index_error, last_corner, output ready);
endinterface

FILE: src/offt_front.sv
`timescale 1ns / 1ps
// offt_front: character parser (stage 1) and index resolve / fan builder
// (stage 2) that pushes whole triangles; depends on offt_pkg, offt_char_if
module offt_front import offt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	offt_char_if.sink  chars,
	output q_ctl_t     qctl_push,
	input  logic       q_full,
	output tri_t       push_data
);

	typedef struct packed {
		logic [IDX_W-1:0] val;
		logic             err;
	} res_t;

	function automatic res_t resolve(input logic [ACC_W-1:0] mag, input logic neg,
		input logic pres, input logic [IDX_W-1:0] cnt);
		res_t             r;
		logic [ACC_W-1:0] v;
		r = '0;
		v = '0;
		if (pres) begin
			if (neg) begin
				if (mag == '0 || mag > ACC_W'(cnt)) r.err = 1'b1;
				else v = ACC_W'(cnt) - mag;
			end else begin
				if (mag == '0) r.err = 1'b1;
				else v = mag - ACC_W'(1);
			end
			if (!r.err) begin
				if ((v >> RANGE_W) != '0) r.err = 1'b1;
				else r.val = v[IDX_W-1:0];
			end
		end
		return r;
	endfunction

	// stage 1 segment state
	logic [ACC_W-1:0] acc_q [NUM_FIELDS];
	logic [NUM_FIELDS-1:0] neg_q;
	logic [NUM_FIELDS-1:0] pres_q;
	logic [1:0]            fnum_q;
	logic                  seen_q;

	logic [ACC_W-1:0] acc_n [NUM_FIELDS];
	logic [NUM_FIELDS-1:0] neg_n;
	logic [NUM_FIELDS-1:0] pres_n;
	logic [1:0]            fnum_n;
	logic                  seen_n;

	// finished segment snapshot
	logic                  v_s1;
	logic                  eol_s1;
	logic                  seen_s1;
	logic [ACC_W-1:0]      acc_s1 [NUM_FIELDS];
	logic [NUM_FIELDS-1:0] neg_s1;
	logic [NUM_FIELDS-1:0] pres_s1;
	logic [IDX_W-1:0]      cnt_s1 [NUM_FIELDS];

	// fan state
	logic [1:0] cc_q;
	corner_t    first_q;
	corner_t    prev_q;

	logic             take;
	logic             finish;
	logic             is_digit;
	logic [1:0]       fsel;
	logic [3:0]       dval;
	logic [ACC_W-1:0] acc_cur;
	logic [ACC_W-1:0] acc_upd;
	logic             need_push;
	logic             s2_go;
	res_t             r_pos, r_tex, r_nrm;
	corner_t          cur;

	assign need_push = seen_s1 && cc_q[1];
	assign s2_go     = !v_s1 || !need_push || !q_full;
	assign chars.ready = s2_go;
	assign take      = chars.valid && chars.ready;
	assign finish    = (chars.char_code == CH_SPACE) || chars.end_of_line;
	assign is_digit  = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
	assign fsel      = (fnum_q == FAN_FULL) ? FIELD_NRM : fnum_q;
	assign dval      = 4'(chars.char_code - CH_ZERO);
	assign acc_cur   = acc_q[fsel];
	assign acc_upd   = (acc_cur > ACC_SAT_LIM) ? ACC_CAP
		: (acc_cur << 3) + (acc_cur << 1) + ACC_W'(dval);

	always_comb begin
		for (int i = 0; i < NUM_FIELDS; i++) acc_n[i] = acc_q[i];
		neg_n  = neg_q;
		pres_n = pres_q;
		fnum_n = fnum_q;
		seen_n = seen_q;
		if (is_digit) begin
			acc_n[fsel]  = acc_upd;
			pres_n[fsel] = 1'b1;
			seen_n       = 1'b1;
		end else if (chars.char_code == CH_MINUS) begin
			neg_n[fsel] = 1'b1;
			seen_n      = 1'b1;
		end else if (chars.char_code == CH_SLASH) begin
			if (fnum_q < FIELD_NRM) fnum_n = fnum_q + 2'd1;
			seen_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FIELDS; i++) acc_q[i] <= '0;
			neg_q  <= '0;
			pres_q <= '0;
			fnum_q <= FIELD_POS;
			seen_q <= 1'b0;
		end else if (take) begin
			if (finish) begin
				for (int i = 0; i < NUM_FIELDS; i++) acc_q[i] <= '0;
				neg_q  <= '0;
				pres_q <= '0;
				fnum_q <= FIELD_POS;
				seen_q <= 1'b0;
			end else begin
				for (int i = 0; i < NUM_FIELDS; i++) acc_q[i] <= acc_n[i];
				neg_q  <= neg_n;
				pres_q <= pres_n;
				fnum_q <= fnum_n;
				seen_q <= seen_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s2_go) begin
			v_s1 <= take && finish;
		end
	end

	always_ff @(posedge clk) begin
		if (take && finish) begin
			eol_s1  <= chars.end_of_line;
			seen_s1 <= seen_n;
			for (int i = 0; i < NUM_FIELDS; i++) acc_s1[i] <= acc_n[i];
			neg_s1    <= neg_n;
			pres_s1   <= pres_n;
			cnt_s1[0] <= chars.position_count;
			cnt_s1[1] <= chars.texcoord_count;
			cnt_s1[2] <= chars.normal_count;
		end
	end

	// stage 2: resolve the finished corner
	always_comb begin
		r_pos = resolve(acc_s1[0], neg_s1[0], pres_s1[0], cnt_s1[0]);
		r_tex = resolve(acc_s1[1], neg_s1[1], pres_s1[1], cnt_s1[1]);
		r_nrm = resolve(acc_s1[2], neg_s1[2], pres_s1[2], cnt_s1[2]);
		cur.pos = r_pos.val;
		cur.tex = r_tex.val;
		cur.tp  = pres_s1[1];
		cur.nrm = r_nrm.val;
		cur.np  = pres_s1[2];
		cur.err = !pres_s1[0] || r_pos.err || r_tex.err || r_nrm.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= '0;
			first_q <= '0;
			prev_q  <= '0;
		end else if (v_s1 && s2_go) begin
			if (eol_s1) begin
				cc_q    <= '0;
				first_q <= '0;
				prev_q  <= '0;
			end else if (seen_s1) begin
				unique case (cc_q)
					2'd0: first_q <= cur;
					default: prev_q <= cur;
				endcase
				if (cc_q != FAN_FULL) cc_q <= cc_q + 2'd1;
			end
		end
	end

	assign qctl_push.push = v_s1 && need_push && !q_full;
	assign push_data = '{c0: first_q, c1: prev_q, c2: cur, last: eol_s1};

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s2_go |=> v_s1 && $stable(cc_q))
		else $error("finished segment dropped while queue full");

endmodule

FILE: src/offt_fifo.sv
`timescale 1ns / 1ps
// offt_fifo: short triangle queue between front and back
// depends on offt_pkg
module offt_fifo import offt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  q_ctl_t qctl_push,
	input  tri_t   push_data,
	output logic   full,
	input  logic   pop,
	output tri_t   pop_data,
	output logic   empty
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	tri_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (qctl_push.push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (qctl_push.push)
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (qctl_push.push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (!qctl_push.push && pop) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qctl_push.push && full && !pop))
		else $error("triangle pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("triangle popped from empty queue");

endmodule

FILE: src/offt_back.sv
`timescale 1ns / 1ps
// offt_back: takes triangles from the queue and sends three corner beats
// depends on offt_pkg, offt_corner_if
module offt_back import offt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  tri_t         pop_data,
	output logic         pop,
	offt_corner_if.source corners
);

	back_state_t state_q, state_d;
	tri_t        tri_q;
	corner_t     sel;
	logic        take_out;
	logic        load;

	assign take_out = corners.valid && corners.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (load) tri_q <= pop_data;
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					load    = 1'b1;
					state_d = BK_FIRST;
				end
			end
			BK_FIRST: if (take_out) state_d = BK_PREV;
			BK_PREV:  if (take_out) state_d = BK_CUR;
			BK_CUR: begin
				if (take_out) begin
					if (!empty) begin
						load    = 1'b1;
						state_d = BK_FIRST;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			BK_PREV: sel = tri_q.c1;
			BK_CUR:  sel = tri_q.c2;
			default: sel = tri_q.c0;
		endcase
	end

	assign pop                      = load;
	assign corners.valid            = (state_q != BK_IDLE);
	assign corners.position_index   = sel.pos;
	assign corners.texcoord_index   = sel.tex;
	assign corners.texcoord_present = sel.tp;
	assign corners.normal_index     = sel.nrm;
	assign corners.normal_present   = sel.np;
	assign corners.index_error      = sel.err;
	assign corners.last_corner      = (state_q == BK_CUR) && tri_q.last;

	a_burst_whole: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(corners.valid) |-> $past(state_q) == BK_CUR && $past(take_out))
		else $error("corner burst cut short");

endmodule

FILE: src/obj_face_fan_triangulator.sv
`timescale 1ns / 1ps
// obj_face_fan_triangulator: face record parser and fan triangulator top
// depends on offt_pkg, offt_char_if, offt_corner_if, offt_front, offt_fifo, offt_back
//
// port     dir   beat
// chars    sink  one record character with position/texcoord/normal counts
// corners  src   one triangle corner (three beats per triangle)
//
// one character per cycle while chars.ready is high; a finished segment is held in the
// stage 1 snapshot until its triangle is pushed into the queue, and the back end loads
// it into its triangle register before offering its first corner beat; the serializer
// sends three corner beats per triangle, so dense faces wait on it once the queue fills
// reset clears segment, fan state and the two-entry triangle queue at once
// a stalled output fills the queue, then holds chars.ready low while a triangle waits
module obj_face_fan_triangulator import offt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	offt_char_if.sink     chars,
	offt_corner_if.source corners
);

	q_ctl_t qctl;
	tri_t   push_data;
	tri_t   pop_data;
	logic   q_full;
	logic   q_empty;
	logic   pop;

	offt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.qctl_push (qctl),
		.q_full    (q_full),
		.push_data (push_data)
	);

	offt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.qctl_push (qctl),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	offt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop_data (pop_data),
		.pop      (pop),
		.corners  (corners)
	);

endmodule

FILE: sim/tb_obj_face_fan_triangulator.sv
`timescale 1ns / 1ps
// tb_obj_face_fan_triangulator: feeds face record characters, predicts each triangle corner
// from its own parser and fan model, and checks every corner beat in order
// depends on offt_pkg, offt_char_if, offt_corner_if, obj_face_fan_triangulator
module tb_obj_face_fan_triangulator;
	import offt_pkg::*;

	localparam int LONG_STALL = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef logic [CHAR_W-1:0] text_t[$];

	typedef struct packed {
		corner_t c;
		logic    last;
	} fan_beat_t;

	logic clk;
	logic arst_n;

	offt_char_if   char_ch ();
	offt_corner_if corner_ch ();

	obj_face_fan_triangulator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_ch),
		.corners (corner_ch)
	);

	fan_beat_t expected_corners[$];
	int fail_count = 0;
	int src_idle_pct = 12;
	int sink_idle_pct = 54;
	int stall_requests = 0;

	// parser and fan state
	corner_t          fan_first;
	corner_t          fan_prev;
	logic [ACC_W-1:0] digit_acc [NUM_FIELDS];
	logic             neg_mark [NUM_FIELDS];
	logic             has_digits [NUM_FIELDS];
	logic [1:0]       field_sel;
	logic             seg_busy;
	logic [1:0]       corners_done;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void drop_segment();
		for (int i = 0; i < NUM_FIELDS; i++) begin
			digit_acc[i] = '0;
			neg_mark[i] = 1'b0;
			has_digits[i] = 1'b0;
		end
		field_sel = FIELD_POS;
		seg_busy = 1'b0;
	endfunction

	function automatic void clear_face();
		drop_segment();
		corners_done = '0;
		fan_first = '0;
		fan_prev = '0;
	endfunction

	// msb is the error mark
	function automatic logic [IDX_W:0] resolve_index(int f, logic [IDX_W-1:0] count);
		logic [63:0] mag;
		logic [63:0] v;
		mag = 64'(digit_acc[f]);
		if (!has_digits[f])
			return '0;
		if (neg_mark[f]) begin
			if (mag == 0 || mag > 64'(count))
				return {1'b1, IDX_W'(0)};
			v = 64'(count) - mag;
		end else begin
			if (mag == 0)
				return {1'b1, IDX_W'(0)};
			v = mag - 1;
		end
		if ((v >> RANGE_W) != 0)
			return {1'b1, IDX_W'(0)};
		return {1'b0, v[IDX_W-1:0]};
	endfunction

	task automatic parse_and_fan(logic [CHAR_W-1:0] ch, logic eol, logic [IDX_W-1:0] pc,
		logic [IDX_W-1:0] tc, logic [IDX_W-1:0] nc);
		int f;
		logic [IDX_W:0] rp;
		logic [IDX_W:0] rt;
		logic [IDX_W:0] rn;
		corner_t c;
		f = int'(field_sel);
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (digit_acc[f] > ACC_SAT_LIM)
				digit_acc[f] = ACC_CAP;
			else
				digit_acc[f] = ACC_W'(digit_acc[f] * 10 + (ch - CH_ZERO));
			has_digits[f] = 1'b1;
			seg_busy = 1'b1;
		end else if (ch == CH_MINUS) begin
			neg_mark[f] = 1'b1;
			seg_busy = 1'b1;
		end else if (ch == CH_SLASH) begin
			if (field_sel != FIELD_NRM)
				field_sel = field_sel + 2'd1;
			seg_busy = 1'b1;
		end
		if ((ch == CH_SPACE || eol) && seg_busy) begin
			rp = resolve_index(0, pc);
			rt = resolve_index(1, tc);
			rn = resolve_index(2, nc);
			c.pos = rp[IDX_W-1:0];
			c.tex = rt[IDX_W-1:0];
			c.tp = has_digits[1];
			c.nrm = rn[IDX_W-1:0];
			c.np = has_digits[2];
			c.err = !has_digits[0] || rp[IDX_W] || rt[IDX_W] || rn[IDX_W];
			drop_segment();
			if (corners_done == 2'd0) begin
				fan_first = c;
			end else if (corners_done == 2'd1) begin
				fan_prev = c;
			end else begin
				expected_corners.push_back('{c: fan_first, last: 1'b0});
				expected_corners.push_back('{c: fan_prev, last: 1'b0});
				expected_corners.push_back('{c: c, last: eol});
				fan_prev = c;
			end
			if (corners_done != FAN_FULL)
				corners_done = corners_done + 2'd1;
		end else if (ch == CH_SPACE || eol) begin
			drop_segment();
		end
		if (eol)
			clear_face();
	endtask

	task automatic send_char(logic [CHAR_W-1:0] ch, logic eol, logic [IDX_W-1:0] pc,
		logic [IDX_W-1:0] tc, logic [IDX_W-1:0] nc);
		while ($urandom_range(99) < src_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_code <= ch;
		char_ch.end_of_line <= eol;
		char_ch.position_count <= pc;
		char_ch.texcoord_count <= tc;
		char_ch.normal_count <= nc;
		do @(posedge clk); while (!char_ch.ready);
		parse_and_fan(ch, eol, pc, tc, nc);
	endtask

	function automatic logic [IDX_W-1:0] pick_count();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return IDX_W'($urandom);
			default: return IDX_W'($urandom_range(30));
		endcase
	endfunction

	task automatic send_record(text_t rec, logic [IDX_W-1:0] pc, logic [IDX_W-1:0] tc,
		logic [IDX_W-1:0] nc, bit vary);
		for (int i = 0; i < rec.size(); i++) begin
			if (vary) begin
				pc = pick_count();
				tc = pick_count();
				nc = pick_count();
			end
			send_char(rec[i], i == rec.size() - 1, pc, tc, nc);
		end
	endtask

	task automatic wait_for_corners();
		char_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_corners.size() != 0);
	endtask

	function automatic text_t text_of(string s);
		text_t t;
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
		return t;
	endfunction

	function automatic text_t index_text();
		string s;
		int kind;
		kind = $urandom_range(19);
		if (kind < 12)
			s = $sformatf("%0d", $urandom_range(20, 1));
		else if (kind < 16)
			s = $sformatf("-%0d", $urandom_range(20, 1));
		else if (kind == 16 && $urandom_range(1))
			s = "0";
		else if (kind == 16)
			s = "-0";
		else if (kind == 17)
			s = $sformatf("%0d", $urandom_range(16777230, 16777210));
		else if (kind == 18 && $urandom_range(1))
			s = "99999999";
		else if (kind == 18)
			s = $sformatf("-%0d", $urandom_range(16777216, 16777200));
		else if ($urandom_range(1))
			s = "";
		else
			s = "4-2";
		return text_of(s);
	endfunction

	function automatic text_t build_face();
		text_t rec;
		int n_corners;
		int form;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(3, 1))
				rec.push_back(CHAR_W'($urandom_range(255)));
			return rec;
		end
		n_corners = ($urandom_range(9) < 2) ? $urandom_range(2, 1) : $urandom_range(6, 3);
		for (int i = 0; i < n_corners; i++) begin
			if (i > 0) begin
				rec.push_back(CH_SPACE);
				if ($urandom_range(7) == 0)
					rec.push_back(CH_SPACE);
			end
			rec = {rec, index_text()};
			form = $urandom_range(3);
			if (form == 1 || form == 3) begin
				rec.push_back(CH_SLASH);
				rec = {rec, index_text()};
			end
			if (form == 2)
				rec = {rec, text_of("/")};
			if (form >= 2) begin
				rec.push_back(CH_SLASH);
				rec = {rec, index_text()};
			end
			if ($urandom_range(15) == 0)
				rec.push_back(CH_SLASH);
			if ($urandom_range(15) == 0)
				rec.push_back(CHAR_W'($urandom_range(255)));
		end
		case ($urandom_range(5))
			0: begin
				rec.push_back(CH_SPACE);
				rec.push_back(CHAR_W'($urandom_range(255)));
			end
			1: rec.push_back(CH_SPACE);
			default: ;
		endcase
		return rec;
	endfunction

	// v, v/vt, v//vn, v/vt/vn with a negative index near the count limit
	task automatic test_fan_forms();
		send_record(text_of("1 2/3 -4//5 6/7/8"), '1, '0, 24'h800000, 1'b0);
		wait_for_corners();
	endtask

	// zero, minus zero, empty segment, missing position, ignored char, range errors
	task automatic test_bad_indices();
		send_record(text_of("0/-0  /9 -7/x/-1 "), 24'd5, '0, 24'd1, 1'b0);
		wait_for_corners();
	endtask

	task automatic test_back_pressure();
		text_t rec;
		for (int i = 1; i <= 12; i++) begin
			rec = {rec, text_of($sformatf("%0d", i))};
			if (i < 12)
				rec.push_back(CH_SPACE);
		end
		stall_requests++;
		send_record(rec, pick_count(), pick_count(), pick_count(), 1'b0);
		wait_for_corners();
	endtask

	task automatic test_random_faces(int n_chars, int src_pct, int sink_pct);
		text_t rec;
		int sent;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < n_chars) begin
			rec = build_face();
			send_record(rec, pick_count(), pick_count(), pick_count(),
				$urandom_range(9) == 0);
			sent += rec.size();
		end
	endtask

	function automatic void check_field(string name, logic [IDX_W-1:0] want,
		logic [IDX_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_corner_beat();
		fan_beat_t want;
		if (expected_corners.size() == 0) begin
			$error("corner beat with nothing expected: position_index %0d",
				corner_ch.position_index);
			fail_count++;
			return;
		end
		want = expected_corners.pop_front();
		check_field("position_index", want.c.pos, corner_ch.position_index);
		check_field("texcoord_index", want.c.tex, corner_ch.texcoord_index);
		check_field("texcoord_present", IDX_W'(want.c.tp), IDX_W'(corner_ch.texcoord_present));
		check_field("normal_index", want.c.nrm, corner_ch.normal_index);
		check_field("normal_present", IDX_W'(want.c.np), IDX_W'(corner_ch.normal_present));
		check_field("index_error", IDX_W'(want.c.err), IDX_W'(corner_ch.index_error));
		check_field("last_corner", IDX_W'(want.last), IDX_W'(corner_ch.last_corner));
	endfunction

	initial begin : corner_sink
		int stall_left;
		int stalls_served;
		stall_left = 0;
		stalls_served = 0;
		corner_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (corner_ch.valid && corner_ch.ready)
				check_corner_beat();
			if (stalls_served < stall_requests) begin
				stall_left = LONG_STALL;
				stalls_served++;
			end
			if (stall_left > 0) begin
				stall_left--;
				corner_ch.ready <= 1'b0;
			end else begin
				corner_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((char_ch.valid && char_ch.ready) || (corner_ch.valid && corner_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		char_ch.valid <= 1'b0;
		char_ch.char_code <= '0;
		char_ch.end_of_line <= 1'b0;
		char_ch.position_count <= '0;
		char_ch.texcoord_count <= '0;
		char_ch.normal_count <= '0;
		clear_face();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fan_forms();
		test_bad_indices();
		test_back_pressure();
		test_random_faces(15, 12, 54);
		test_random_faces(15, 54, 12);
		test_random_faces(15, 0, 0);
		wait_for_corners();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
